@@ hdl/gsmad_pkg.sv @@
// Shared types and constants for the gyro stick mixer with radial anti-deadzone.
package gsmad_pkg;

  // Full stick deflection, in stick steps and in 1/256 steps.
  localparam int unsigned STICK_MAX    = 32767;
  localparam int unsigned STICK_MAX_Q8 = 32767 * 256;

  // Gyro gain per half step of sensitivity.
  localparam int unsigned GAIN_PER_HALF = 5000;

  // Anti-deadzone target term: full deflection in 1/65536 steps.
  localparam longint unsigned ADZ_FULL = 64'd32767 * 64'd65536;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_SENS      = 3'd0,
    REG_INV_YAW   = 3'd1,
    REG_INV_PITCH = 3'd2,
    REG_ADZ       = 3'd3,
    REG_ALWAYS_ON = 3'd4
  } reg_idx_t;

  // One item as it travels down the pipeline, in sign and magnitude form.
  typedef struct packed {
    logic               vld;
    logic               act;
    logic               rsc;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [43:0]        mx;
    logic [43:0]        my;
    logic               nx;
    logic               ny;
  } item_t;

endpackage

@@ hdl/gyro_stick_mixer_anti_deadzone.sv @@
// Top level: gyro to stick mixer with radial anti-deadzone, fully pipelined.
//
// Input transactions carry one gyro sample (pitch and yaw rate), the right
// stick and the aim flag on in_valid / in_stall. Each produces exactly one
// output transaction with the mixed stick on out_valid / out_stall.
// One transaction can enter in every cycle while the pipeline is not stalled;
// the pipeline holds the 32-stage square root (one root bit per stage), the
// 26-stage divider (one quotient bit per stage) and seven stages of gain,
// squaring, mixing and the split 23x40 product.
// The configuration registers sit on an APB-style port at byte addresses
// 0, 4, 8, 12 and 16; pready is always high and reads return the values.
// The registers must only be written while no transaction is in flight.
// A synchronous reset empties the pipeline and loads the register defaults.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises; nothing is lost or repeated. An empty output register
// lets the pipeline advance even while out_stall is high.
module gyro_stick_mixer_anti_deadzone
  import gsmad_pkg::*;
#(
  parameter int GYRO_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] gyro_pitch,
  input  logic signed [23:0] gyro_yaw,
  input  logic signed [15:0] stick_x,
  input  logic signed [15:0] stick_y,
  input  logic               aim_active,
  // Output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] mixed_x,
  output logic signed [15:0] mixed_y,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SH     = GYRO_FRAC_BITS - 8;
  localparam int SQ_N   = 32;
  localparam int DIV_N  = 26;
  localparam logic [46:0] SQ_LIM  = 47'(STICK_MAX_Q8) * 47'(STICK_MAX_Q8);
  localparam logic [43:0] MAG_LIM = 44'(STICK_MAX_Q8);

  // Configuration registers; gain holds sensitivity times 5000.
  logic [6:0]  sens;
  logic        inv_yaw;
  logic        inv_pitch;
  logic [6:0]  adz;
  logic        always_on;
  logic [19:0] gain;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens      <= 7'd10;
      inv_yaw   <= 1'b0;
      inv_pitch <= 1'b0;
      adz       <= 7'd0;
      always_on <= 1'b0;
      gain      <= 20'(10 * GAIN_PER_HALF);
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_SENS: begin
          sens <= pwdata[6:0];
          gain <= 20'(pwdata[6:0] * 20'(GAIN_PER_HALF));
        end
        REG_INV_YAW:   inv_yaw   <= pwdata[0];
        REG_INV_PITCH: inv_pitch <= pwdata[0];
        REG_ADZ:       adz       <= pwdata[6:0];
        REG_ALWAYS_ON: always_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:2])
      REG_SENS:      prdata = {25'd0, sens};
      REG_INV_YAW:   prdata = {31'd0, inv_yaw};
      REG_INV_PITCH: prdata = {31'd0, inv_pitch};
      REG_ADZ:       prdata = {25'd0, adz};
      REG_ALWAYS_ON: prdata = {31'd0, always_on};
      default:       prdata = 32'd0;
    endcase
  end

  // The pipeline advances whenever the output register can take a result.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage A: rate magnitudes times gain.
  item_t      a_it;
  logic [23:0] yaw_mag, pitch_mag;
  assign yaw_mag   = gyro_yaw[23]   ? 24'(-gyro_yaw)   : 24'(gyro_yaw);
  assign pitch_mag = gyro_pitch[23] ? 24'(-gyro_pitch) : 24'(gyro_pitch);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_it.vld <= 1'b0;
    end else if (en) begin
      a_it.vld <= in_valid;
      a_it.act <= aim_active | always_on;
      a_it.rsc <= 1'b0;
      a_it.sx  <= stick_x;
      a_it.sy  <= stick_y;
      a_it.mx  <= {20'd0, yaw_mag} * {24'd0, gain};
      a_it.my  <= {20'd0, pitch_mag} * {24'd0, gain};
      a_it.nx  <= gyro_yaw[23] ^ ~inv_yaw;
      a_it.ny  <= gyro_pitch[23] ^ inv_pitch;
    end
  end

  // Stage B: scale to 1/256 steps, range check and square.
  item_t       b_it;
  item_t       b_next;
  logic [45:0] b_sqx, b_sqy;
  logic        b_inr;
  logic [43:0] sh_x, sh_y;
  assign sh_x = a_it.mx >> SH;
  assign sh_y = a_it.my >> SH;

  always_comb begin
    b_next    = a_it;
    b_next.mx = sh_x;
    b_next.my = sh_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_it.vld <= 1'b0;
    end else if (en) begin
      b_it    <= b_next;
      b_inr   <= (sh_x <= MAG_LIM) && (sh_y <= MAG_LIM);
      b_sqx   <= {23'd0, sh_x[22:0]} * {23'd0, sh_x[22:0]};
      b_sqy   <= {23'd0, sh_y[22:0]} * {23'd0, sh_y[22:0]};
    end
  end

  // Stage C: squared magnitude and the rescale decision.
  item_t       c_it;
  item_t       c_next;
  logic [46:0] c_s;
  logic [46:0] s_sum;
  assign s_sum = {1'b0, b_sqx} + {1'b0, b_sqy};

  always_comb begin
    c_next     = b_it;
    c_next.rsc = b_it.act && (adz != 7'd0) && b_inr &&
                 (s_sum >= 47'd7) && (s_sum <= SQ_LIM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_it.vld <= 1'b0;
    end else if (en) begin
      c_it     <= c_next;
      c_s      <= s_sum;
    end
  end

  // Square root of s * 65536, one root bit per stage.
  item_t       sq_it   [1:SQ_N];
  logic [32:0] sq_rem  [1:SQ_N];
  logic [31:0] sq_root [1:SQ_N];
  logic [46:0] sq_s    [1:SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    item_t       it_in;
    logic [32:0] rem_in;
    logic [31:0] root_in;
    logic [46:0] s_in;
    logic [63:0] x;
    logic [34:0] rem2;
    logic [34:0] trial;

    if (k == 0) begin : g_head
      assign it_in   = c_it;
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = c_s;
    end else begin : g_body
      assign it_in   = sq_it[k];
      assign rem_in  = sq_rem[k];
      assign root_in = sq_root[k];
      assign s_in    = sq_s[k];
    end

    assign x     = {1'b0, s_in, 16'd0};
    assign rem2  = {rem_in[32:0], x[63-2*k -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_it[k+1].vld <= 1'b0;
      end else if (en) begin
        sq_it[k+1] <= it_in;
        sq_s[k+1]  <= s_in;
        if (rem2 >= trial) begin
          sq_rem[k+1]  <= 33'(rem2 - trial);
          sq_root[k+1] <= {root_in[30:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= rem2[32:0];
          sq_root[k+1] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  // Stage N: rescale numerator and divisor.
  item_t       n_it;
  logic [39:0] n_num;
  logic [38:0] n_den;
  logic [6:0]  dz_c;
  logic [31:0] r_fin;
  assign dz_c  = (adz > 7'd100) ? 7'd100 : adz;
  assign r_fin = sq_root[SQ_N];

  always_ff @(posedge clk) begin
    if (rst) begin
      n_it.vld <= 1'b0;
    end else if (en) begin
      n_it  <= sq_it[SQ_N];
      n_num <= ({33'd0, 7'd100 - dz_c} * {8'd0, r_fin}) +
               ({33'd0, dz_c} * 40'(ADZ_FULL));
      n_den <= {7'd0, r_fin} * 39'd100;
    end
  end

  // Stage P: partial products of magnitude times numerator.
  item_t       p_it;
  logic [42:0] p_x0, p_x1, p_y0, p_y1;
  logic [38:0] p_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_it.vld <= 1'b0;
    end else if (en) begin
      p_it  <= n_it;
      p_den <= n_den;
      p_x0  <= {20'd0, n_it.mx[22:0]} * {23'd0, n_num[19:0]};
      p_x1  <= {20'd0, n_it.mx[22:0]} * {23'd0, n_num[39:20]};
      p_y0  <= {20'd0, n_it.my[22:0]} * {23'd0, n_num[19:0]};
      p_y1  <= {20'd0, n_it.my[22:0]} * {23'd0, n_num[39:20]};
    end
  end

  // Stage Q: full dividends.
  item_t       q_it;
  logic [62:0] q_dx, q_dy;
  logic [38:0] q_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_it.vld <= 1'b0;
    end else if (en) begin
      q_it  <= p_it;
      q_den <= p_den;
      q_dx  <= 63'(p_x0) + (63'(p_x1) << 20);
      q_dy  <= 63'(p_y0) + (63'(p_y1) << 20);
    end
  end

  // Restoring divider, two lanes, one quotient bit per stage.
  item_t       dv_it  [1:DIV_N];
  logic [38:0] dv_den [1:DIV_N];
  logic [62:0] dv_num [1:DIV_N][2];
  logic [38:0] dv_rem [1:DIV_N][2];
  logic [25:0] dv_quo [1:DIV_N][2];

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    item_t       it_in;
    logic [38:0] den_in;

    if (k == 0) begin : g_head
      assign it_in  = q_it;
      assign den_in = q_den;
    end else begin : g_body
      assign it_in  = dv_it[k];
      assign den_in = dv_den[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_it[k+1].vld <= 1'b0;
      end else if (en) begin
        dv_it[k+1]  <= it_in;
        dv_den[k+1] <= den_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [62:0] num_in;
      logic [38:0] rem_in;
      logic [25:0] quo_in;
      logic [39:0] rem2;

      if (k == 0) begin : g_head
        assign num_in = (l == 0) ? q_dx : q_dy;
        assign rem_in = {2'b00, num_in[62:26]};
        assign quo_in = '0;
      end else begin : g_body
        assign num_in = dv_num[k][l];
        assign rem_in = dv_rem[k][l];
        assign quo_in = dv_quo[k][l];
      end

      assign rem2 = {rem_in, num_in[25-k]};

      always_ff @(posedge clk) begin
        if (en) begin
          dv_num[k+1][l] <= num_in;
          if (rem2 >= {1'b0, den_in}) begin
            dv_rem[k+1][l] <= 39'(rem2 - {1'b0, den_in});
            dv_quo[k+1][l] <= {quo_in[24:0], 1'b1};
          end else begin
            dv_rem[k+1][l] <= rem2[38:0];
            dv_quo[k+1][l] <= {quo_in[24:0], 1'b0};
          end
        end
      end
    end
  end

  // Stage M: add to the stick, saturate and truncate toward zero.
  item_t       m_it;
  logic [43:0] fx, fy;
  logic signed [15:0] mix_x, mix_y;
  logic        o_act;

  assign m_it = dv_it[DIV_N];
  assign fx = m_it.rsc ? {18'd0, dv_quo[DIV_N][0]} : m_it.mx;
  assign fy = m_it.rsc ? {18'd0, dv_quo[DIV_N][1]} : m_it.my;

  function automatic logic signed [15:0] mix_one(logic signed [15:0] st,
                                                 logic [43:0] f, logic neg);
    logic signed [45:0] sf;
    logic signed [45:0] c;
    logic [45:0]        cm;
    logic [15:0]        v;
    sf = neg ? -$signed({2'b00, f}) : $signed({2'b00, f});
    c  = ($signed(46'(st)) <<< 8) + sf;
    cm = c[45] ? 46'(-c) : 46'(c);
    v  = 16'(cm >> 8);
    if (c > $signed(46'(STICK_MAX_Q8))) begin
      mix_one = 16'(STICK_MAX);
    end else if (c < -$signed(46'(STICK_MAX_Q8))) begin
      mix_one = -16'(STICK_MAX);
    end else begin
      mix_one = c[45] ? 16'(-v) : 16'(v);
    end
  endfunction

  assign mix_x = m_it.act ? mix_one(m_it.sx, fx, m_it.nx) : m_it.sx;
  assign mix_y = m_it.act ? mix_one(m_it.sy, fy, m_it.ny) : m_it.sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_it.vld;
      mixed_x   <= mix_x;
      mixed_y   <= mix_y;
      o_act     <= m_it.act;
    end
  end

  // The square root result is the floor root of s * 65536.
  a_sqrt_floor: assert property (@(posedge clk) disable iff (rst)
    sq_it[SQ_N].vld && sq_it[SQ_N].rsc |->
      (64'(sq_root[SQ_N]) * 64'(sq_root[SQ_N]) <= {1'b0, sq_s[SQ_N], 16'd0}) &&
      (65'(sq_root[SQ_N]) + 65'd1) * (65'(sq_root[SQ_N]) + 65'd1) >
        {2'b00, sq_s[SQ_N], 16'd0})
    else $error("square root stage out of range");

  // The final divider remainders stay below the divisor for a rescaled vector.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv_it[DIV_N].vld && dv_it[DIV_N].rsc |->
      (dv_rem[DIV_N][0] < dv_den[DIV_N]) && (dv_rem[DIV_N][1] < dv_den[DIV_N]))
    else $error("divider remainder not below divisor");

  // A mixed result is always saturated to the symmetric range.
  a_mix_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && o_act |-> (mixed_x != 16'sh8000) && (mixed_y != 16'sh8000))
    else $error("mixed output outside symmetric range");

  // A held result keeps the pipeline frozen in the next cycle.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(dv_quo[DIV_N][0]) && $stable(m_it))
    else $error("pipeline moved while output stalled");

endmodule
